### rtl/nce_pkg.sv
// Package for the nibble CPU execute unit.
// Holds the payload structs, action and pending-read codes, and the decode classes.
// No dependencies.
`timescale 1ns / 1ps

package nce_pkg;

    localparam int STACK_DEPTH = 4;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       func;
        logic [7:0] opcode;
        logic [7:0] operand;
        logic [7:0] read_data;
        logic       test_pin;
    } nce_in_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [11:0] address;
        logic [3:0]  bank;
        logic [1:0]  char_index;
        logic [3:0]  write_data;
        logic [11:0] next_pc;
        logic [3:0]  acc_out;
        logic        carry_out;
    } nce_out_t;

    typedef enum logic [3:0] {
        ACT_DONE       = 4'd0,
        ACT_SRC        = 4'd1,
        ACT_RAM_WR     = 4'd2,
        ACT_RAMPORT_WR = 4'd3,
        ACT_ROMPORT_WR = 4'd4,
        ACT_STATUS_WR  = 4'd5,
        ACT_RAM_RD     = 4'd6,
        ACT_ROMPORT_RD = 4'd7,
        ACT_STATUS_RD  = 4'd8,
        ACT_FETCH_RD   = 4'd9,
        ACT_ILLEGAL    = 4'd10,
        ACT_PROTO_ERR  = 4'd11
    } action_t;

    typedef enum logic [2:0] {
        PEND_NONE = 3'd0,
        PEND_RDM  = 3'd1,
        PEND_ADM  = 3'd2,
        PEND_SBM  = 3'd3,
        PEND_RDR  = 3'd4,
        PEND_RDX  = 3'd5,
        PEND_FIN  = 3'd6
    } pend_t;

    typedef enum logic [4:0] {
        CLS_ANSWER,
        CLS_NOP,
        CLS_JCN,
        CLS_FIM,
        CLS_SRC,
        CLS_FIN,
        CLS_JIN,
        CLS_JUN,
        CLS_JMS,
        CLS_INC,
        CLS_ISZ,
        CLS_ADD,
        CLS_SUB,
        CLS_LD,
        CLS_XCH,
        CLS_BBL,
        CLS_LDM,
        CLS_IO,
        CLS_ACC,
        CLS_ILLEGAL
    } op_class_t;

    typedef struct packed {
        nce_in_t   item;
        op_class_t cls;
    } q_entry_t;

endpackage

### rtl/nibble_cpu_instruction_execute_unit.sv
// Nibble CPU execute unit, top level: decode queue in front, executor behind it.
// A request is written into the queue, then executed into the output register.
// Throughput: one request per cycle; the executor retires one queued request a cycle unless m_ready stalls it.
// A full two-entry queue with a stalled result side backs up to s_ready.
// Reset (aresetn low, synchronous): registers, stack, PC, acc, carry cleared, bank = 1.
// Depends on nce_pkg, nce_front, nce_back.
`timescale 1ns / 1ps

module nibble_cpu_instruction_execute_unit import nce_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  nce_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output nce_out_t m_data
);

    logic     q_valid;
    logic     q_pop;
    q_entry_t q_entry;

    nce_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    nce_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_pop_needs_entry : assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_bank_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.bank != 4'd0))
        else $error("bank select code is zero");

    a_wdata_quiet : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.action == ACT_DONE || m_data.action == ACT_SRC
            || m_data.action == ACT_PROTO_ERR)) |-> (m_data.write_data == 4'd0))
        else $error("write data driven on a non-write action");

    a_result_follows_pop : assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid)
        else $error("executed request produced no result");
`endif

endmodule

### rtl/nce_front.sv
// Front end: accepts requests, decodes them into instruction classes and queues them.
// Depends on nce_pkg.
`timescale 1ns / 1ps

module nce_front import nce_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  nce_in_t  s_data,
    output logic     q_valid,
    output q_entry_t q_entry,
    input  logic     q_pop
);

    q_entry_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    op_class_t         cls;
    logic              push;
    logic [3:0]        hi;
    logic [3:0]        lo;

    assign hi = s_data.opcode[7:4];
    assign lo = s_data.opcode[3:0];

    always_comb begin
        cls = CLS_NOP;
        if (s_data.func) begin
            cls = CLS_ANSWER;
        end else begin
            case (hi)
                4'h0: cls = CLS_NOP;
                4'h1: cls = CLS_JCN;
                4'h2: cls = lo[0] ? CLS_SRC : CLS_FIM;
                4'h3: cls = lo[0] ? CLS_JIN : CLS_FIN;
                4'h4: cls = CLS_JUN;
                4'h5: cls = CLS_JMS;
                4'h6: cls = CLS_INC;
                4'h7: cls = CLS_ISZ;
                4'h8: cls = CLS_ADD;
                4'h9: cls = CLS_SUB;
                4'hA: cls = CLS_LD;
                4'hB: cls = CLS_XCH;
                4'hC: cls = CLS_BBL;
                4'hD: cls = CLS_LDM;
                4'hE: cls = (lo == 4'h3) ? CLS_ILLEGAL : CLS_IO;
                default: cls = (lo inside {4'hE, 4'hF}) ? CLS_ILLEGAL : CLS_ACC;
            endcase
        end
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_entry = entry_reg[head_reg];

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push) begin
            tail_next = (tail_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (q_pop) begin
            head_next = (head_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[tail_reg] <= '{item: s_data, cls: cls};
        end
    end

endmodule

### rtl/nce_back.sv
// Back end: executes one queued instruction per cycle against the register state
// and holds the result in an output register, which m_ready can stall. Depends on nce_pkg.
`timescale 1ns / 1ps

module nce_back import nce_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    input  q_entry_t q_entry,
    output logic     q_pop,
    output logic     m_valid,
    input  logic     m_ready,
    output nce_out_t m_data
);

    // index registers kept as eight pairs: odd register in the upper nibble
    logic [7:0]      pair_reg [8];
    logic [11:0]     stack_reg [STACK_DEPTH];
    logic [11:0]     pc_reg, pc_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [3:0]      acc_reg, acc_next;
    logic            carry_reg, carry_next;
    logic [3:0]      bank_reg, bank_next;
    pend_t           pend_reg, pend_next;
    logic [3:0]      tgt_reg, tgt_next;
    logic            m_valid_reg;
    nce_out_t        m_data_reg;

    logic [SP_W-1:0] sp_inc, sp_dec;
    logic [7:0]      opc, opd, rd;
    logic [3:0]      lo, nib, reg_val, reg_inc;
    logic [7:0]      pair_val;
    logic [11:0]     pc_p1, pc_p2;
    logic [4:0]      sum;
    logic [4:0]      acc_p6;
    logic            any_cond;
    logic            pair_we;
    logic [2:0]      pair_idx;
    logic [7:0]      pair_wdata;
    logic            stk_we;
    logic [11:0]     stk_wdata;
    action_t         action;
    logic [11:0]     address;
    logic [1:0]      chr;
    logic [3:0]      wdata;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    assign opc      = q_entry.item.opcode;
    assign opd      = q_entry.item.operand;
    assign rd       = q_entry.item.read_data;
    assign lo       = opc[3:0];
    assign nib      = rd[3:0];
    assign pair_val = pair_reg[lo[3:1]];
    assign reg_val  = lo[0] ? pair_val[7:4] : pair_val[3:0];
    assign reg_inc  = reg_val + 4'd1;
    assign pc_p1    = pc_reg + 12'd1;
    assign pc_p2    = pc_reg + 12'd2;
    assign sp_inc   = (sp_reg == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec   = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign acc_p6   = {1'b0, acc_reg} + 5'd6;
    assign any_cond = ((acc_reg == 4'd0) & lo[2]) | (carry_reg & lo[1])
                    | (~q_entry.item.test_pin & lo[0]);

    always_comb begin
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        acc_next   = acc_reg;
        carry_next = carry_reg;
        bank_next  = bank_reg;
        pend_next  = pend_reg;
        tgt_next   = tgt_reg;
        pair_we    = 1'b0;
        pair_idx   = lo[3:1];
        pair_wdata = pair_val;
        stk_we     = 1'b0;
        stk_wdata  = pc_p2;
        action     = ACT_DONE;
        address    = '0;
        chr        = '0;
        wdata      = '0;
        sum        = '0;

        if (q_entry.cls == CLS_ANSWER) begin
            if (pend_reg == PEND_NONE) begin
                action = ACT_PROTO_ERR;
            end else begin
                case (pend_reg)
                    PEND_ADM: begin
                        sum        = {1'b0, acc_reg} + {1'b0, nib} + {4'd0, carry_reg};
                        acc_next   = sum[3:0];
                        carry_next = sum[4];
                    end
                    PEND_SBM: begin
                        sum        = {1'b0, acc_reg} + {1'b0, ~nib} + {4'd0, carry_reg};
                        acc_next   = sum[3:0];
                        carry_next = sum[4];
                    end
                    PEND_FIN: begin
                        pair_we    = 1'b1;
                        pair_idx   = tgt_reg[3:1];
                        pair_wdata = rd;
                    end
                    default: acc_next = nib;
                endcase
                pend_next = PEND_NONE;
                tgt_next  = '0;
            end
        end else if (pend_reg != PEND_NONE) begin
            action = ACT_PROTO_ERR;
        end else begin
            pc_next = pc_p1;
            case (q_entry.cls)
                CLS_JCN: begin
                    pc_next = (lo[3] ^ any_cond) ? {pc_p2[11:8], opd} : pc_p2;
                end
                CLS_SRC: begin
                    action  = ACT_SRC;
                    address = {4'd0, pair_val};
                end
                CLS_FIM: begin
                    pair_we    = 1'b1;
                    pair_wdata = opd;
                    pc_next    = pc_p2;
                end
                CLS_JIN: pc_next = {pc_p1[11:8], pair_val};
                CLS_FIN: begin
                    action    = ACT_FETCH_RD;
                    address   = {pc_p1[11:8], pair_reg[0]};
                    pend_next = PEND_FIN;
                    tgt_next  = {lo[3:1], 1'b0};
                end
                CLS_JUN: pc_next = {lo, opd};
                CLS_JMS: begin
                    stk_we    = 1'b1;
                    stk_wdata = pc_p2;
                    sp_next   = sp_inc;
                    pc_next   = {lo, opd};
                end
                CLS_INC, CLS_ISZ: begin
                    pair_we    = 1'b1;
                    pair_wdata = lo[0] ? {reg_inc, pair_val[3:0]} : {pair_val[7:4], reg_inc};
                    if (q_entry.cls == CLS_ISZ) begin
                        pc_next = (reg_inc != 4'd0) ? {pc_p2[11:8], opd} : pc_p2;
                    end
                end
                CLS_ADD: begin
                    sum        = {1'b0, acc_reg} + {1'b0, reg_val} + {4'd0, carry_reg};
                    acc_next   = sum[3:0];
                    carry_next = sum[4];
                end
                CLS_SUB: begin
                    sum        = {1'b0, acc_reg} + {1'b0, ~reg_val} + {4'd0, carry_reg};
                    acc_next   = sum[3:0];
                    carry_next = sum[4];
                end
                CLS_LD: acc_next = reg_val;
                CLS_XCH: begin
                    acc_next   = reg_val;
                    pair_we    = 1'b1;
                    pair_wdata = lo[0] ? {acc_reg, pair_val[3:0]} : {pair_val[7:4], acc_reg};
                end
                CLS_BBL: begin
                    // park the live PC in the slot being left
                    acc_next  = lo;
                    stk_we    = 1'b1;
                    stk_wdata = pc_reg;
                    sp_next   = sp_dec;
                    pc_next   = stack_reg[sp_dec];
                end
                CLS_LDM: acc_next = lo;
                CLS_IO: begin
                    case (lo)
                        4'h0: begin action = ACT_RAM_WR;     wdata = acc_reg; end
                        4'h1: begin action = ACT_RAMPORT_WR; wdata = acc_reg; end
                        4'h2: begin action = ACT_ROMPORT_WR; wdata = acc_reg; end
                        4'h4, 4'h5, 4'h6, 4'h7: begin
                            action = ACT_STATUS_WR;
                            chr    = lo[1:0];
                            wdata  = acc_reg;
                        end
                        4'h8: begin action = ACT_RAM_RD;     pend_next = PEND_SBM; end
                        4'h9: begin action = ACT_RAM_RD;     pend_next = PEND_RDM; end
                        4'hA: begin action = ACT_ROMPORT_RD; pend_next = PEND_RDR; end
                        4'hB: begin action = ACT_RAM_RD;     pend_next = PEND_ADM; end
                        4'hC, 4'hD, 4'hE, 4'hF: begin
                            action    = ACT_STATUS_RD;
                            chr       = lo[1:0];
                            pend_next = PEND_RDX;
                        end
                        default: action = ACT_ILLEGAL;
                    endcase
                end
                CLS_ACC: begin
                    case (lo)
                        4'h0: begin acc_next = '0; carry_next = 1'b0; end
                        4'h1: carry_next = 1'b0;
                        4'h2: begin
                            sum        = {1'b0, acc_reg} + 5'd1;
                            acc_next   = sum[3:0];
                            carry_next = sum[4];
                        end
                        4'h3: carry_next = ~carry_reg;
                        4'h4: acc_next = ~acc_reg;
                        4'h5: begin
                            carry_next = acc_reg[3];
                            acc_next   = {acc_reg[2:0], carry_reg};
                        end
                        4'h6: begin
                            carry_next = acc_reg[0];
                            acc_next   = {carry_reg, acc_reg[3:1]};
                        end
                        4'h7: begin acc_next = {3'd0, carry_reg}; carry_next = 1'b0; end
                        4'h8: begin
                            sum        = {1'b0, acc_reg} + 5'hF;
                            acc_next   = sum[3:0];
                            carry_next = sum[4];
                        end
                        4'h9: begin
                            acc_next   = carry_reg ? 4'd10 : 4'd9;
                            carry_next = 1'b0;
                        end
                        4'hA: carry_next = 1'b1;
                        4'hB: begin
                            // decimal adjust can only set the carry
                            if (acc_reg > 4'd9 || carry_reg) begin
                                acc_next   = acc_p6[3:0];
                                carry_next = carry_reg | acc_p6[4];
                            end
                        end
                        4'hC: begin
                            case (acc_reg)
                                4'h0, 4'h1, 4'h2: acc_next = acc_reg;
                                4'h4: acc_next = 4'h3;
                                4'h8: acc_next = 4'h4;
                                default: acc_next = 4'hF;
                            endcase
                        end
                        4'hD: bank_next = (acc_reg[2:0] == 3'd0) ? 4'd1 : {acc_reg[2:0], 1'b0};
                        default: action = ACT_ILLEGAL;
                    endcase
                end
                CLS_ILLEGAL: action = ACT_ILLEGAL;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= '0;
            sp_reg      <= '0;
            acc_reg     <= '0;
            carry_reg   <= 1'b0;
            bank_reg    <= 4'd1;
            pend_reg    <= PEND_NONE;
            tgt_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                pair_reg[i] <= '0;
            end
            for (int i = 0; i < STACK_DEPTH; i++) begin
                stack_reg[i] <= '0;
            end
        end else begin
            if (q_pop) begin
                pc_reg    <= pc_next;
                sp_reg    <= sp_next;
                acc_reg   <= acc_next;
                carry_reg <= carry_next;
                bank_reg  <= bank_next;
                pend_reg  <= pend_next;
                tgt_reg   <= tgt_next;
                if (pair_we) begin
                    pair_reg[pair_idx] <= pair_wdata;
                end
                if (stk_we) begin
                    stack_reg[sp_reg] <= stk_wdata;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= '{action: action, address: address, bank: bank_next,
                            char_index: chr, write_data: wdata, next_pc: pc_next,
                            acc_out: acc_next, carry_out: carry_next};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
